FILE: design/assert_macros.svh
// Assertion macros shared by the heat stencil modules.
// No dependencies; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HS3_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HS3_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HS3_ASSERT(lbl, clk, rst, prop, msg)
`define HS3_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: design/hs3_pkg.sv
// Types, constants and helper functions of the 3D heat stencil unit.
// No dependencies; hs3_front, hs3_back and the top unit import it.
package hs3_pkg;

   localparam int SAMPLE_BITS    = 32;
   localparam int FRAC_BITS      = 16;
   localparam int COEFF_BITS     = 18;
   localparam int XSIZE_BITS     = 7;
   localparam int YSIZE_BITS     = 7;
   localparam int ZSIZE_BITS     = 11;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 18;

   localparam int DEF_MAX_X = 64;
   localparam int DEF_MAX_Y = 64;
   localparam int DEF_MAX_Z = 1024;

   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 8;

   localparam logic [XSIZE_BITS-1:0] X_SIZE_RESET = 7'd64;
   localparam logic [YSIZE_BITS-1:0] Y_SIZE_RESET = 7'd64;
   localparam logic [ZSIZE_BITS-1:0] Z_SIZE_RESET = 11'd64;
   localparam logic signed [COEFF_BITS-1:0] CENTER_COEFF_RESET = 18'sd26214;
   localparam logic signed [COEFF_BITS-1:0] NEIGHBOR_COEFF_RESET = 18'sd6554;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_X_SIZE       = 3'd0,
      CSR_Y_SIZE       = 3'd1,
      CSR_Z_SIZE       = 3'd2,
      CSR_CENTER_COEFF = 3'd3,
      CSR_X_COEFF      = 3'd4,
      CSR_Y_COEFF      = 3'd5,
      CSR_Z_COEFF      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          volume_start;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] updated_value;
      logic                          last_point;
   } rsp_type;

   typedef struct packed {
      logic        [XSIZE_BITS-1:0] x_size;
      logic        [YSIZE_BITS-1:0] y_size;
      logic        [ZSIZE_BITS-1:0] z_size;
      logic signed [COEFF_BITS-1:0] center_coeff;
      logic signed [COEFF_BITS-1:0] x_coeff;
      logic signed [COEFF_BITS-1:0] y_coeff;
      logic signed [COEFF_BITS-1:0] z_coeff;
   } cfg_type;

   // A size of zero acts as one; a size above the maximum acts as the maximum.
   function automatic int unsigned eff_size(int unsigned v, int unsigned max);
      if (v == 0) begin
         return 1;
      end
      return (v > max) ? max : v;
   endfunction

   // Width of one command word: sample, five addresses and seven flags.
   function automatic int cmd_bits(int aw);
      return SAMPLE_BITS + 5 * aw + 7;
   endfunction

endpackage

FILE: design/hs3_ram.sv
// Generic single-write, single-read RAM with a registered, read-first output.
// No dependencies.
module hs3_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // A read at the written address returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: design/hs3_fifo.sv
// Small register queue used between the front and back and for results.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module hs3_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `HS3_ASSERT(a_fifo_no_overflow, clock, reset, !(push && full), "push into a full queue")
   `HS3_ASSERT(a_fifo_count_bound, clock, reset, count_ff <= CNT_BITS'(DEPTH), "queue count out of range")
   `HS3_ASSERT(a_fifo_count_up, clock, reset, (do_push && !do_pop) |=> (count_ff == $past(count_ff) + CNT_BITS'(1)), "queue count did not advance")

endmodule

FILE: design/hs3_front.sv
// Front of the heat stencil: accepts samples, tracks the raster position and
// emits one store/compute command per sample up to the top ghost plane. Depends on hs3_pkg.
module hs3_front
   import hs3_pkg::*;
#(
   parameter int MAX_X = DEF_MAX_X,
   parameter int MAX_Y = DEF_MAX_Y,
   parameter int MAX_Z = DEF_MAX_Z
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_push,
   input  req_type req_data,
   input  logic    cmd_full,
   output logic    cmd_push,
   output logic [cmd_bits((MAX_X * MAX_Y > 1) ? $clog2(MAX_X * MAX_Y) : 1)-1:0] cmd_data
);

   localparam int CW  = (MAX_X > 1) ? $clog2(MAX_X) : 1;
   localparam int RW  = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
   localparam int XSW = $clog2(MAX_X + 1);
   localparam int YSW = $clog2(MAX_Y + 1);
   localparam int ZSW = $clog2(MAX_Z + 1);
   localparam int PW  = $clog2(MAX_Z + 3);
   localparam int AW  = (MAX_X * MAX_Y > 1) ? $clog2(MAX_X * MAX_Y) : 1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [AW-1:0] addr_c;
      logic [AW-1:0] addr_e;
      logic [AW-1:0] addr_w;
      logic [AW-1:0] addr_n;
      logic [AW-1:0] addr_s;
      logic bnd_e;
      logic bnd_w;
      logic bnd_n;
      logic bnd_s;
      logic has_result;
      logic last_point;
      logic store_sel;
   } cmd_type;

   logic [CW-1:0]     col_ff, col_in, col_cur;
   logic [RW-1:0]     row_ff, row_in, row_cur;
   logic [PW-1:0]     plane_ff, plane_in, plane_cur;
   logic              sel_ff, sel_in, sel_cur;
   logic [XSW-1:0]    xs;
   logic [YSW-1:0]    ys;
   logic [ZSW-1:0]    zs;
   logic [PW-1:0]     zs1;
   logic [RW+XSW:0]   idx_full;
   logic [AW-1:0]     idx, xs_step;
   logic              accept, live, col_last, row_last;
   cmd_type           cmd;

   // Sizes in force, clamped to the supported range.
   assign xs  = XSW'(eff_size(32'(cfg.x_size), MAX_X));
   assign ys  = YSW'(eff_size(32'(cfg.y_size), MAX_Y));
   assign zs  = ZSW'(eff_size(32'(cfg.z_size), MAX_Z));
   assign zs1 = PW'(zs) + PW'(1);

   // A volume start restarts the raster at the bottom ghost plane.
   assign col_cur   = req_data.volume_start ? '0 : col_ff;
   assign row_cur   = req_data.volume_start ? '0 : row_ff;
   assign plane_cur = req_data.volume_start ? '0 : plane_ff;
   assign sel_cur   = req_data.volume_start ? 1'b0 : sel_ff;

   assign accept   = req_push && !cmd_full;
   assign live     = (plane_cur <= zs1);
   assign col_last = (XSW'(col_cur) + XSW'(1)) >= xs;
   assign row_last = (YSW'(row_cur) + YSW'(1)) >= ys;

   assign idx_full = row_cur * xs + col_cur;
   assign idx      = idx_full[AW-1:0];
   assign xs_step  = AW'(xs);

   // Command for the back: addresses, edge flags and result marking.
   always_comb begin
      cmd.sample     = req_data.sample;
      cmd.addr_c     = idx;
      cmd.addr_e     = idx + AW'(1);
      cmd.addr_w     = idx - AW'(1);
      cmd.addr_n     = idx + xs_step;
      cmd.addr_s     = idx - xs_step;
      cmd.bnd_e      = col_last;
      cmd.bnd_w      = (col_cur == '0);
      cmd.bnd_n      = row_last;
      cmd.bnd_s      = (row_cur == '0);
      cmd.has_result = (plane_cur >= PW'(2));
      cmd.last_point = (plane_cur == zs1) && row_last && col_last;
      cmd.store_sel  = sel_cur;
   end

   assign cmd_push = accept && live;
   assign cmd_data = cmd;

   // Raster counters; samples past the top ghost plane leave them alone.
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      plane_in = plane_ff;
      sel_in   = sel_ff;
      if (accept && live) begin
         col_in   = col_last ? '0 : col_cur + CW'(1);
         row_in   = row_cur;
         plane_in = plane_cur;
         sel_in   = sel_cur;
         if (col_last) begin
            row_in = row_last ? '0 : row_cur + RW'(1);
            if (row_last) begin
               plane_in = plane_cur + PW'(1);
               sel_in   = !sel_cur;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         plane_ff <= '0;
         sel_ff   <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         plane_ff <= plane_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

FILE: design/hs3_back.sv
// Back of the heat stencil: plane stores, neighbor selection, multiply-add,
// rounding and saturation. Depends on hs3_pkg, hs3_ram and assert_macros.svh.
`include "assert_macros.svh"
module hs3_back
   import hs3_pkg::*;
#(
   parameter int MAX_X = DEF_MAX_X,
   parameter int MAX_Y = DEF_MAX_Y
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_empty,
   input  logic [cmd_bits((MAX_X * MAX_Y > 1) ? $clog2(MAX_X * MAX_Y) : 1)-1:0] cmd_data,
   output logic    cmd_pop,
   input  logic    rsp_taken,
   output logic    res_push,
   output rsp_type res_data
);

   localparam int AW    = (MAX_X * MAX_Y > 1) ? $clog2(MAX_X * MAX_Y) : 1;
   localparam int DEPTH = MAX_X * MAX_Y;
   localparam int SB    = SAMPLE_BITS;
   localparam int PRODW = COEFF_BITS + SB + 1;
   localparam int SUMW  = PRODW + 3;
   localparam int RESW  = SUMW - FRAC_BITS;
   localparam int RCW   = $clog2(RSP_DEPTH + 1);
   localparam int TAPS  = 5;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [AW-1:0] addr_c;
      logic [AW-1:0] addr_e;
      logic [AW-1:0] addr_w;
      logic [AW-1:0] addr_n;
      logic [AW-1:0] addr_s;
      logic bnd_e;
      logic bnd_w;
      logic bnd_n;
      logic bnd_s;
      logic has_result;
      logic last_point;
      logic store_sel;
   } cmd_type;

   cmd_type          cmd;
   logic [AW-1:0]    rd_addr [TAPS];
   logic [SB-1:0]    rd_a [TAPS];
   logic [SB-1:0]    rd_b [TAPS];
   logic             wr_a, wr_b, credit_ok;
   logic [RCW-1:0]   reserved_ff, reserved_in;

   // Stage 1: command whose store data is arriving.
   logic             rd_valid_ff;
   cmd_type          rd_cmd_ff;
   logic signed [SB-1:0] cur [TAPS];
   logic signed [SB-1:0] old_val, c_v, e_v, w_v, n_v, s_v;

   // Stage 2: operands after pairwise pre-add.
   logic               opr_valid_ff, opr_last_ff;
   logic signed [SB-1:0] opr_c_ff;
   logic signed [SB:0]   opr_ew_ff, opr_ns_ff, opr_tb_ff;

   // Stage 3: products.
   logic                  prod_valid_ff, prod_last_ff;
   logic signed [PRODW-1:0] prod_c_ff, prod_x_ff, prod_y_ff, prod_z_ff;

   // Stage 4: rounded sum.
   logic                 sum_valid_ff, sum_last_ff;
   logic signed [SUMW-1:0] sum_ff;
   logic signed [RESW-1:0] res_wide;
   logic                 res_fits;

   assign cmd = cmd_type'(cmd_data);

   // Issue a command when it needs no result slot or one is still free.
   assign credit_ok = (reserved_ff < RCW'(RSP_DEPTH));
   assign cmd_pop   = !cmd_empty && (!cmd.has_result || credit_ok);

   // The sample is written into the older store, which frees at this plane.
   assign wr_a = cmd_pop && cmd.store_sel;
   assign wr_b = cmd_pop && !cmd.store_sel;

   assign rd_addr[0] = cmd.addr_c;
   assign rd_addr[1] = cmd.addr_e;
   assign rd_addr[2] = cmd.addr_w;
   assign rd_addr[3] = cmd.addr_n;
   assign rd_addr[4] = cmd.addr_s;

   // Each store has one copy per tap so all neighbors are read in the same cycle.
   for (genvar k = 0; k < TAPS; k++) begin : g_tap
      hs3_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_ram_a (
         .clock  (clock),
         .wr_en  (wr_a),
         .wr_addr(cmd.addr_c),
         .wr_data(cmd.sample),
         .rd_en  (cmd_pop),
         .rd_addr(rd_addr[k]),
         .rd_data(rd_a[k])
      );
      hs3_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_ram_b (
         .clock  (clock),
         .wr_en  (wr_b),
         .wr_addr(cmd.addr_c),
         .wr_data(cmd.sample),
         .rd_en  (cmd_pop),
         .rd_addr(rd_addr[k]),
         .rd_data(rd_b[k])
      );
      assign cur[k] = rd_cmd_ff.store_sel ? signed'(rd_b[k]) : signed'(rd_a[k]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         opr_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff   <= cmd_pop && cmd.has_result;
         opr_valid_ff  <= rd_valid_ff;
         prod_valid_ff <= opr_valid_ff;
         sum_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rd_cmd_ff <= cmd;
      end
   end

   // Edge neighbors repeat the center value.
   always_comb begin
      old_val = rd_cmd_ff.store_sel ? signed'(rd_a[0]) : signed'(rd_b[0]);
      c_v = cur[0];
      e_v = rd_cmd_ff.bnd_e ? cur[0] : cur[1];
      w_v = rd_cmd_ff.bnd_w ? cur[0] : cur[2];
      n_v = rd_cmd_ff.bnd_n ? cur[0] : cur[3];
      s_v = rd_cmd_ff.bnd_s ? cur[0] : cur[4];
   end

   always_ff @(posedge clock) begin
      opr_last_ff <= rd_cmd_ff.last_point;
      opr_c_ff    <= c_v;
      opr_ew_ff   <= (SB+1)'(e_v) + (SB+1)'(w_v);
      opr_ns_ff   <= (SB+1)'(n_v) + (SB+1)'(s_v);
      opr_tb_ff   <= (SB+1)'(rd_cmd_ff.sample) + (SB+1)'(old_val);
   end

   // One multiplier per weight; both operands are sign-extended to the
   // full product width so no product bits are lost.
   always_ff @(posedge clock) begin
      prod_last_ff <= opr_last_ff;
      prod_c_ff    <= PRODW'(cfg.center_coeff) * PRODW'(opr_c_ff);
      prod_x_ff    <= PRODW'(cfg.x_coeff) * PRODW'(opr_ew_ff);
      prod_y_ff    <= PRODW'(cfg.y_coeff) * PRODW'(opr_ns_ff);
      prod_z_ff    <= PRODW'(cfg.z_coeff) * PRODW'(opr_tb_ff);
   end

   // Sum the products and add one half for rounding toward plus infinity.
   always_ff @(posedge clock) begin
      sum_last_ff <= prod_last_ff;
      sum_ff      <= SUMW'(prod_c_ff) + SUMW'(prod_x_ff) + SUMW'(prod_y_ff)
                   + SUMW'(prod_z_ff) + (SUMW'(1) <<< (FRAC_BITS - 1));
   end

   // Drop the fraction and saturate to the sample width.
   assign res_wide = RESW'(sum_ff >>> FRAC_BITS);
   assign res_fits = (res_wide[RESW-1:SB-1] == '0) || (res_wide[RESW-1:SB-1] == '1);

   always_comb begin
      res_data.last_point = sum_last_ff;
      if (res_fits) begin
         res_data.updated_value = res_wide[SB-1:0];
      end else if (res_wide[RESW-1]) begin
         res_data.updated_value = {1'b1, {(SB-1){1'b0}}};
      end else begin
         res_data.updated_value = {1'b0, {(SB-1){1'b1}}};
      end
   end

   assign res_push = sum_valid_ff;

   // Result slots held by work in flight or waiting in the result queue.
   always_comb begin
      reserved_in = reserved_ff;
      if ((cmd_pop && cmd.has_result) && !rsp_taken) begin
         reserved_in = reserved_ff + RCW'(1);
      end else if (!(cmd_pop && cmd.has_result) && rsp_taken) begin
         reserved_in = reserved_ff - RCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= '0;
      end else begin
         reserved_ff <= reserved_in;
      end
   end

   `HS3_ASSERT(a_back_credit_bound, clock, reset, reserved_ff <= RCW'(RSP_DEPTH), "result slots over-reserved")
   `HS3_ASSERT(a_back_push_reserved, clock, reset, res_push |-> (reserved_ff != '0), "result pushed without a slot")
   `HS3_ASSERT(a_back_take_reserved, clock, reset, rsp_taken |-> (reserved_ff != '0), "result taken without a slot")

endmodule

FILE: design/heat_stencil_3d_7pt_unit.sv
// Results pass the command queue, read, operand, product and sum stages and the
// result queue. Throughput: one sample per cycle while result slots are free,
// set by the five-copy plane stores and four-stage multiply-add pipeline;
// result queue depth 8 absorbs stalls. Reset: synchronous, clears counters,
// queues and registers; plane stores are not cleared, need no clearing pass.
// Depends on hs3_pkg, hs3_front, hs3_fifo and hs3_back.
module heat_stencil_3d_7pt_unit
   import hs3_pkg::*;
#(
   parameter int MAX_X = DEF_MAX_X,
   parameter int MAX_Y = DEF_MAX_Y,
   parameter int MAX_Z = DEF_MAX_Z
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  req_type                   req_data,
   output logic                      req_full,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output rsp_type                   rsp_data,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int AW     = (MAX_X * MAX_Y > 1) ? $clog2(MAX_X * MAX_Y) : 1;
   localparam int CMD_W  = cmd_bits(AW);
   localparam int RSP_W  = $bits(rsp_type);

   cfg_type          cfg_ff, cfg_in;
   logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic [CMD_W-1:0] cmd_wdata, cmd_rdata;
   logic             res_push, rsp_taken;
   rsp_type          res_data;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_X_SIZE:       cfg_in.x_size       = csr_write_data[XSIZE_BITS-1:0];
            CSR_Y_SIZE:       cfg_in.y_size       = csr_write_data[YSIZE_BITS-1:0];
            CSR_Z_SIZE:       cfg_in.z_size       = csr_write_data[ZSIZE_BITS-1:0];
            CSR_CENTER_COEFF: cfg_in.center_coeff = csr_write_data[COEFF_BITS-1:0];
            CSR_X_COEFF:      cfg_in.x_coeff      = csr_write_data[COEFF_BITS-1:0];
            CSR_Y_COEFF:      cfg_in.y_coeff      = csr_write_data[COEFF_BITS-1:0];
            CSR_Z_COEFF:      cfg_in.z_coeff      = csr_write_data[COEFF_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_size       <= X_SIZE_RESET;
         cfg_ff.y_size       <= Y_SIZE_RESET;
         cfg_ff.z_size       <= Z_SIZE_RESET;
         cfg_ff.center_coeff <= CENTER_COEFF_RESET;
         cfg_ff.x_coeff      <= NEIGHBOR_COEFF_RESET;
         cfg_ff.y_coeff      <= NEIGHBOR_COEFF_RESET;
         cfg_ff.z_coeff      <= NEIGHBOR_COEFF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full  = cmd_full;
   assign rsp_taken = rsp_pop && !rsp_empty;

   hs3_front #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)) u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .req_push(req_push),
      .req_data(req_data),
      .cmd_full(cmd_full),
      .cmd_push(cmd_push),
      .cmd_data(cmd_wdata)
   );

   // Command queue between front and back.
   hs3_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_data(cmd_wdata),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .pop_data (cmd_rdata),
      .empty    (cmd_empty)
   );

   hs3_back #(.MAX_X(MAX_X), .MAX_Y(MAX_Y)) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .cmd_empty(cmd_empty),
      .cmd_data (cmd_rdata),
      .cmd_pop  (cmd_pop),
      .rsp_taken(rsp_taken),
      .res_push (res_push),
      .res_data (res_data)
   );

   // Result queue; the back never pushes more than it has reserved.
   hs3_fifo #(.WIDTH(RSP_W), .DEPTH(RSP_DEPTH)) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (res_push),
      .push_data(res_data),
      .full     (),
      .pop      (rsp_pop),
      .pop_data (rsp_data),
      .empty    (rsp_empty)
   );

endmodule
